// ===== src/pcbd_pkg.sv =====
// shared constants and types of the prefix code bit decoder
package pcbd_pkg;

  localparam int NUM_SYMBOLS_DEF  = 97;
  localparam int MAX_CODE_LEN_DEF = 32;

  localparam int INDEX_W    = 7;
  localparam int CODE_W     = 32;
  localparam int CODE_LEN_W = 6;
  localparam int SYM_W      = 7;
  localparam int SUM_W      = 9;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 8;

  localparam logic [SUM_W-1:0] SYM_OFFSET  = 9'd32;
  localparam logic [SYM_W-1:0] SYM_NEWLINE = 7'd10;
  localparam logic [SYM_W-1:0] SYM_NONE    = 7'd0;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef struct packed {
    logic                  opcode;
    logic [INDEX_W-1:0]    entry_index;
    logic [CODE_W-1:0]     code_bits;
    logic [CODE_LEN_W-1:0] code_length;
    logic                  bit_in;
  } pcbd_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             code_error;
  } pcbd_result_t;

endpackage

// ===== src/prefix_code_bit_decoder_core.sv =====
// top level of the prefix code bit decoder
// load item: taken while idle, no result; next item may follow at once
// decode item: every entry is read once from the memories, one per cycle; an
//   item that returns a result then waits in S_DONE until the result is taken
// a result passes from S_DONE into the output register; a held output stalls it
// synchronous active-low reset clears the loaded marks, the position and the epoch;
//   memory contents are not cleared
module prefix_code_bit_decoder_core #(
  parameter int NUM_SYMBOLS  = pcbd_pkg::NUM_SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = pcbd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // entry_index, code_bits, code_length, bit_in
  input  logic [pcbd_pkg::IN_TDATA_W-1:0]  in_tdata,
  // opcode
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // symbol
  output logic [pcbd_pkg::OUT_TDATA_W-1:0] out_tdata,
  // code_error
  output logic                             out_tuser
);

  import pcbd_pkg::*;

  localparam int IW = $clog2(NUM_SYMBOLS);
  localparam int LW = $clog2(MAX_CODE_LEN + 1);
  localparam int DW = LW + CODE_W;

  pcbd_item_t    in_item;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic [IW-1:0] rd_addr;
  logic [DW-1:0] rd_data;
  logic          rl_wr_en;
  logic [IW-1:0] rl_wr_addr;
  logic [1:0]    rl_wr_data;
  logic [1:0]    rl_rd_data;
  logic          res_valid;
  logic          res_ready;
  pcbd_result_t  res;
  logic          out_valid_r;
  pcbd_result_t  out_res_r;

  assign in_item.opcode      = in_tuser;
  assign in_item.entry_index = in_tdata[6:0];
  assign in_item.code_bits   = in_tdata[38:7];
  assign in_item.code_length = in_tdata[44:39];
  assign in_item.bit_in      = in_tdata[45];

  pcbd_entry_mem #(
    .DEPTH (NUM_SYMBOLS),
    .AW    (IW),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ruled-out marks with their epoch tags
  pcbd_entry_mem #(
    .DEPTH (NUM_SYMBOLS),
    .AW    (IW),
    .DW    (2)
  ) u_ruled_mem (
    .clk     (clk),
    .wr_en   (rl_wr_en),
    .wr_addr (rl_wr_addr),
    .wr_data (rl_wr_data),
    .rd_addr (rd_addr),
    .rd_data (rl_rd_data)
  );

  pcbd_scan #(
    .NUM_SYMBOLS  (NUM_SYMBOLS),
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .IW           (IW),
    .LW           (LW),
    .DW           (DW)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .rl_wr_en   (rl_wr_en),
    .rl_wr_addr (rl_wr_addr),
    .rl_wr_data (rl_wr_data),
    .rl_rd_data (rl_rd_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register lets the scan finish while the previous item waits
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-SYM_W){1'b0}}, out_res_r.symbol};
  assign out_tuser  = out_res_r.code_error;

endmodule

// ===== src/pcbd_entry_mem.sv =====
// entry memory for the codebook and the ruled-out marks: one write port, one registered read port
module pcbd_entry_mem #(
  parameter int DEPTH = 97,
  parameter int AW    = 7,
  parameter int DW    = 38
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/pcbd_scan.sv =====
// sequencer: takes items, loads the codebook and scans it one entry per cycle
module pcbd_scan #(
  parameter int NUM_SYMBOLS  = 97,
  parameter int MAX_CODE_LEN = 32,
  parameter int IW           = 7,
  parameter int LW           = 6,
  parameter int DW           = 38
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pcbd_pkg::pcbd_item_t  in_item,
  output logic                  wr_en,
  output logic [IW-1:0]         wr_addr,
  output logic [DW-1:0]         wr_data,
  output logic [IW-1:0]         rd_addr,
  input  logic [DW-1:0]         rd_data,
  output logic                  rl_wr_en,
  output logic [IW-1:0]         rl_wr_addr,
  output logic [1:0]            rl_wr_data,
  input  logic [1:0]            rl_rd_data,
  output logic                  res_valid,
  input  logic                  res_ready,
  output pcbd_pkg::pcbd_result_t res
);

  import pcbd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SYMBOLS - 1);
  localparam logic [LW:0]   MAX_POS  = (LW+1)'(MAX_CODE_LEN);

  logic [1:0]             state_r, state_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic [LW-1:0]          pos_r, pos_nxt;
  logic                   bit_r, bit_nxt;
  logic                   any_live_r, any_live_nxt;
  logic                   hit_r, hit_nxt;
  logic                   epoch_r, epoch_nxt;
  logic [NUM_SYMBOLS-1:0] loaded_r, loaded_nxt;
  pcbd_result_t           res_r, res_nxt;

  logic                   accept;
  logic                   load_ok;
  logic [LW-1:0]          len_sat;
  logic [LW-1:0]          e_len;
  logic [CODE_W-1:0]      e_code;
  logic [CODE_W-1:0]      code_sh;
  logic                   ruled_old;
  logic                   ruled_new;
  logic                   live;
  logic                   mismatch;
  logic [LW:0]            pos_inc;
  logic                   complete;
  logic                   any_now;
  logic                   hit_now;
  logic                   first_load;
  logic                   scan_wr;
  logic [SUM_W-1:0]       sym_sum;
  logic [SYM_W-1:0]       hit_sym;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // load path writes the memory straight from the item
  assign load_ok = (32'(in_item.entry_index) < NUM_SYMBOLS);
  assign len_sat = (32'(in_item.code_length) > MAX_CODE_LEN) ? LW'(MAX_CODE_LEN)
                                                             : LW'(in_item.code_length);
  assign wr_en   = accept && (in_item.opcode == OP_LOAD) && load_ok;
  assign wr_addr = IW'(in_item.entry_index);
  assign wr_data = {len_sat, in_item.code_bits};

  // read one entry ahead of the one being checked
  assign rd_addr = (state_r == S_SCAN && idx_r != LAST_IDX) ? idx_r + 1'b1 : '0;

  // a ruled-out mark counts only while its epoch tag matches; flipping the epoch
  // clears every mark, since each scan rewrites all entries with the current tag
  assign ruled_old = rl_rd_data[1] && (rl_rd_data[0] == epoch_r);

  assign e_len    = rd_data[DW-1 -: LW];
  assign e_code   = rd_data[CODE_W-1:0];
  assign code_sh  = e_code >> pos_r;
  assign live     = loaded_r[idx_r] && !ruled_old;
  assign mismatch = (pos_r >= e_len) || (code_sh[0] != bit_r);
  assign pos_inc  = {1'b0, pos_r} + 1'b1;
  assign complete = (pos_inc == {1'b0, e_len});
  assign any_now  = any_live_r || (live && !mismatch);
  assign hit_now  = hit_r || (live && !mismatch && complete);

  assign ruled_new  = loaded_r[idx_r] && (ruled_old || mismatch);
  // first load of an entry starts it with no ruled-out mark
  assign first_load = wr_en && !loaded_r[wr_addr];
  assign scan_wr    = (state_r == S_SCAN);
  assign rl_wr_en   = scan_wr || first_load;
  assign rl_wr_addr = scan_wr ? idx_r : wr_addr;
  assign rl_wr_data = scan_wr ? {ruled_new, epoch_r} : {1'b0, epoch_r};

  assign sym_sum = {{(SUM_W-IW){1'b0}}, idx_r} + SYM_OFFSET;
  assign hit_sym = (idx_r == LAST_IDX) ? SYM_NEWLINE : sym_sum[SYM_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    bit_nxt      = bit_r;
    any_live_nxt = any_live_r;
    hit_nxt      = hit_r;
    epoch_nxt    = epoch_r;
    loaded_nxt   = loaded_r;
    res_nxt      = res_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.opcode == OP_DECODE) begin
            state_nxt    = S_SCAN;
            idx_nxt      = '0;
            any_live_nxt = 1'b0;
            hit_nxt      = 1'b0;
            bit_nxt      = in_item.bit_in;
          end else if (load_ok) begin
            loaded_nxt[wr_addr] = 1'b1;
          end
        end
      end
      S_SCAN: begin
        // after a hit the scan only walks on to refresh the tags
        if (!hit_r && live && !mismatch) begin
          if (complete) begin
            hit_nxt = 1'b1;
            res_nxt = '{symbol: hit_sym, code_error: 1'b0};
          end else begin
            any_live_nxt = 1'b1;
          end
        end
        if (idx_r == LAST_IDX) begin
          if (hit_now) begin
            state_nxt = S_DONE;
            pos_nxt   = '0;
            epoch_nxt = !epoch_r;
          end else if (!any_now || pos_inc >= MAX_POS) begin
            res_nxt   = '{symbol: SYM_NONE, code_error: 1'b1};
            state_nxt = S_DONE;
            pos_nxt   = '0;
            epoch_nxt = !epoch_r;
          end else begin
            pos_nxt   = pos_inc[LW-1:0];
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pos_r    <= '0;
      epoch_r  <= 1'b0;
      loaded_r <= '0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      epoch_r  <= epoch_nxt;
      loaded_r <= loaded_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    bit_r      <= bit_nxt;
    any_live_r <= any_live_nxt;
    hit_r      <= hit_nxt;
    res_r      <= res_nxt;
  end

  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

// ===== dv/prefix_code_bit_decoder_core_test.sv =====
// testbench of the prefix code bit decoder: random codebooks, bit streams and stalls
`timescale 1ns / 100ps

module prefix_code_bit_decoder_core_test;
  import pcbd_pkg::*;

  localparam int NSYM      = NUM_SYMBOLS_DEF;
  localparam int MAXLEN    = MAX_CODE_LEN_DEF;
  localparam int ITEM_GOAL = 1300;
  localparam int QUIET_AT  = 1100;

  // tracks the decoder state and the symbols it should produce
  class symbol_tracker;
    logic [CODE_W-1:0] code_mem[NSYM];
    int unsigned       len_mem[NSYM];
    bit                loaded[NSYM];
    bit                dropped[NSYM];
    int unsigned       position;
    pcbd_result_t      expected_symbols[$];
    int                errors;

    function new();
      for (int i = 0; i < NSYM; i++) begin
        loaded[i]  = 0;
        dropped[i] = 0;
      end
      position = 0;
      errors   = 0;
    endfunction

    function void restart_match();
      for (int i = 0; i < NSYM; i++) dropped[i] = 0;
      position = 0;
    endfunction

    function void push_symbol(logic [SYM_W-1:0] sym, logic err);
      pcbd_result_t r;
      r.symbol     = sym;
      r.code_error = err;
      expected_symbols.push_back(r);
    endfunction

    function void accept_item(pcbd_item_t it);
      bit          any_live;
      logic        code_bit;
      int unsigned len;
      any_live = 0;
      if (it.opcode == OP_LOAD) begin
        if (it.entry_index < NSYM) begin
          len = (it.code_length > MAXLEN) ? MAXLEN : it.code_length;
          code_mem[it.entry_index] = it.code_bits;
          len_mem[it.entry_index]  = len;
          loaded[it.entry_index]   = 1;
        end
        return;
      end
      for (int i = 0; i < NSYM; i++) begin
        if (!loaded[i] || dropped[i]) continue;
        code_bit = (position < CODE_W) ? code_mem[i][position] : 1'b0;
        if (position >= len_mem[i] || code_bit != it.bit_in) begin
          dropped[i] = 1;
          continue;
        end
        if (position + 1 == len_mem[i]) begin
          if (i == NSYM - 1) push_symbol(SYM_NEWLINE, 1'b0);
          else push_symbol(SYM_W'(i + SYM_OFFSET), 1'b0);
          restart_match();
          return;
        end
        any_live = 1;
      end
      position++;
      if (!any_live || position >= MAXLEN) begin
        push_symbol(SYM_NONE, 1'b1);
        restart_match();
      end
    endfunction

    function void check_symbol(logic [SYM_W-1:0] sym, logic err);
      pcbd_result_t want;
      if (expected_symbols.size() == 0) begin
        $display("%0t: unexpected result symbol=%0d code_error=%0b", $time, sym, err);
        errors++;
        return;
      end
      want = expected_symbols.pop_front();
      if (sym !== want.symbol) begin
        $display("%0t: symbol expected %0d actual %0d", $time, want.symbol, sym);
        errors++;
      end
      if (err !== want.code_error) begin
        $display("%0t: code_error expected %0b actual %0b", $time, want.code_error, err);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  symbol_tracker tracker;

  // what the stimulus side has loaded, used to build matching bit streams
  logic [CODE_W-1:0] book_code[NSYM];
  int unsigned       book_len[NSYM];
  bit                book_loaded[NSYM];
  int                items_sent;
  bit                quiet;

  prefix_code_bit_decoder_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_symbol(out_tdata[SYM_W-1:0], out_tuser);
  end

  // result side: random stall bursts, none near the end
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input pcbd_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tdata  <= {2'b00, it.bit_in, it.code_length, it.code_bits, it.entry_index};
    in_tuser  <= it.opcode;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.accept_item(it);
    if (it.opcode == OP_DECODE || it.entry_index < NSYM) items_sent++;
    quiet = (items_sent >= QUIET_AT);
  endtask

  task automatic load_entry(input int idx, input logic [CODE_W-1:0] code, input int len);
    pcbd_item_t it;
    it.opcode      = OP_LOAD;
    it.entry_index = INDEX_W'(idx);
    it.code_bits   = code;
    it.code_length = CODE_LEN_W'(len);
    it.bit_in      = 1'($urandom_range(0, 1));
    if (idx < NSYM) begin
      book_code[idx]   = code;
      book_len[idx]    = (len > MAXLEN) ? MAXLEN : len;
      book_loaded[idx] = 1;
    end
    send_item(it);
  endtask

  task automatic decode_bit(input logic b);
    pcbd_item_t it;
    it.opcode      = OP_DECODE;
    it.entry_index = INDEX_W'($urandom);
    it.code_bits   = $urandom;
    it.code_length = CODE_LEN_W'($urandom);
    it.bit_in      = b;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_symbols.size() != 0) @(posedge clk);
  endtask

  // streams the code of a loaded entry, sometimes cut short, or a noise bit
  task automatic stream_codes(input int nbits);
    int sent_bits;
    int idx;
    int cut;
    bit found;
    sent_bits = 0;
    while (sent_bits < nbits) begin
      found = 0;
      for (int t = 0; t < 8 && !found; t++) begin
        idx = $urandom_range(0, NSYM - 1);
        found = book_loaded[idx] && book_len[idx] > 0;
      end
      if (!found || $urandom_range(0, 7) == 0) begin
        decode_bit(1'($urandom_range(0, 1)));
        sent_bits++;
      end else begin
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, book_len[idx]) : book_len[idx];
        for (int p = 0; p < cut; p++) decode_bit(book_code[idx][p]);
        sent_bits += cut;
      end
    end
  endtask

  initial begin
    int style;
    int len;
    int idx;
    int sel;
    tracker    = new();
    items_sent = 0;
    quiet      = 0;
    for (int i = 0; i < NSYM; i++) book_loaded[i] = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_LOAD;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty codebook errors on every bit, out-of-range slot is ignored
    decode_bit(1'b0);
    load_entry(127, 32'h0000_0000, 5);
    decode_bit(1'b1);
    // newline entry, zero length entry, saturated length with all ones
    load_entry(96, 32'h0000_0001, 2);
    load_entry(5, 32'h0000_0000, 0);
    load_entry(0, 32'hFFFF_FFFF, 63);
    decode_bit(1'b1);
    decode_bit(1'b0);
    load_entry(3, 32'h0000_0000, 1);
    decode_bit(1'b0);
    // full length code running to the last position
    load_entry(64, 32'hA5C3_3C5A, 32);
    load_entry(3, 32'hFFFF_FFFE, 33);
    for (int p = 0; p < CODE_W; p++) decode_bit(book_code[64][p]);
    decode_bit(1'b1);
    decode_bit(1'b1);
    wait_drained();

    while (items_sent < ITEM_GOAL) begin
      style = $urandom_range(0, 3);
      if (style == 0) begin
        // fixed 7-bit codes, a prefix-free codebook that fills every entry
        for (int i = 0; i < NSYM; i++) load_entry(i, {$urandom} << 7 | i, 7);
      end else begin
        repeat ($urandom_range(1, 12)) begin
          idx = ($urandom_range(0, 15) == 0) ? $urandom_range(NSYM, 127)
                                             : $urandom_range(0, NSYM - 1);
          sel = $urandom_range(0, 19);
          if (sel == 0) len = 0;
          else if (sel == 1) len = $urandom_range(13, 63);
          else len = $urandom_range(1, 8);
          load_entry(idx, $urandom, len);
        end
      end
      stream_codes($urandom_range(10, 40));
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (NSYM + 10) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/pcbd_pkg.sv
src/pcbd_entry_mem.sv
src/pcbd_scan.sv
src/prefix_code_bit_decoder_core.sv
dv/prefix_code_bit_decoder_core_test.sv
